// ===== hdl/mslb_pkg.sv =====
// shared types and constants for the multi-slot led blinker
`default_nettype none

package mslb_pkg;

    localparam int MASK_W  = 32;
    localparam int COUNT_W = 7;
    localparam int CD_W    = COUNT_W + 1;

    localparam logic ACTION_REQUEST = 1'b0;
    localparam logic ACTION_TICK    = 1'b1;

    typedef struct packed {
        logic              overlap;
        logic              free_found;
        logic [MASK_W-1:0] high;
        logic [MASK_W-1:0] low;
    } slot_status_t;

endpackage

`default_nettype wire

// ===== hdl/mslb_slots.sv =====
// blink slot table: overlap check, free slot pick and per-tick toggling
`default_nettype none

module mslb_slots
    import mslb_pkg::*;
#(
    parameter int SLOT_COUNT = 5
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_en,
    input  wire logic               tick_en,
    input  wire logic [MASK_W-1:0]  mask,
    input  wire logic [COUNT_W-1:0] count,
    output slot_status_t            status
);

    logic [MASK_W-1:0] slot_pins_reg      [SLOT_COUNT];
    logic [MASK_W-1:0] slot_pins_next     [SLOT_COUNT];
    logic [CD_W-1:0]   slot_countdown_reg [SLOT_COUNT];
    logic [CD_W-1:0]   slot_countdown_next[SLOT_COUNT];
    logic              slot_lit_reg       [SLOT_COUNT];
    logic              slot_lit_next      [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] pick;

    always_comb
    begin
        logic found;
        found          = 1'b0;
        status.overlap = 1'b0;
        status.high    = '0;
        status.low     = '0;
        pick           = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if ((slot_pins_reg[i] & mask) != '0)
                status.overlap = 1'b1;
            // lowest free slot wins
            if (slot_pins_reg[i] == '0 && !found)
            begin
                pick[i] = 1'b1;
                found   = 1'b1;
            end
        end
        status.free_found = found;

        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_pins_next[i]      = slot_pins_reg[i];
            slot_countdown_next[i] = slot_countdown_reg[i];
            slot_lit_next[i]       = slot_lit_reg[i];
            if (tick_en && slot_countdown_reg[i] != '0)
            begin
                if (slot_lit_reg[i])
                    status.low = status.low | slot_pins_reg[i];
                else
                    status.high = status.high | slot_pins_reg[i];
                slot_lit_next[i]       = ~slot_lit_reg[i];
                slot_countdown_next[i] = slot_countdown_reg[i] - CD_W'(1);
                if (slot_countdown_reg[i] == CD_W'(1))
                    slot_pins_next[i] = '0;
            end
            if (req_en && !status.overlap && pick[i])
            begin
                slot_pins_next[i]      = mask;
                slot_countdown_next[i] = {count, 1'b0};
                slot_lit_next[i]       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_pins_reg[i]      <= '0;
                slot_countdown_reg[i] <= '0;
                slot_lit_reg[i]       <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_pins_reg[i]      <= slot_pins_next[i];
                slot_countdown_reg[i] <= slot_countdown_next[i];
                slot_lit_reg[i]       <= slot_lit_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/multi_slot_led_blinker_core.sv =====
// top level of the multi-slot led blinker
//
// One word (blink request or interval tick) is taken per cycle: busy stays
// low. A word is registered at the edge where start is high and worked
// through the slot table in the following cycle. Its result is loaded at the
// next edge and shows on the result ports with done high for exactly one
// cycle. It passes through the input registers and then the result
// registers. The receiver cannot stall, so results must be captured when
// done is high.
// Back to back words see the slot state left by the word before them.
// led_pin_mask must be written through cfg_valid/cfg_data while no word is
// in flight (not enforced by the block); cfg_ready is always high.
`default_nettype none

module multi_slot_led_blinker_core
    import mslb_pkg::*;
#(
    parameter int SLOT_COUNT = 5
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               action,
    input  wire logic [MASK_W-1:0]  pin_mask,
    input  wire logic [COUNT_W-1:0] blink_count,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [MASK_W-1:0]  cfg_data,
    output logic                    done,
    output logic                    write_valid,
    output logic [MASK_W-1:0]       drive_high_mask,
    output logic [MASK_W-1:0]       drive_low_mask,
    output logic                    accepted,
    output logic                    timer_running
);

    logic               item_valid_reg;
    logic               action_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [MASK_W-1:0]  led_pin_mask_reg;
    logic               timer_reg;
    logic               timer_next;

    logic               done_reg;
    logic               write_valid_reg;
    logic               write_valid_next;
    logic [MASK_W-1:0]  high_reg;
    logic [MASK_W-1:0]  high_next;
    logic [MASK_W-1:0]  low_reg;
    logic [MASK_W-1:0]  low_next;
    logic               accepted_reg;
    logic               accepted_next;

    logic               req_en;
    logic               tick_en;
    logic               gathered;
    slot_status_t       status;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // zero mask or zero count requests are dropped here
    assign req_en  = item_valid_reg && action_reg == ACTION_REQUEST
                     && mask_reg != '0 && count_reg != '0;
    assign tick_en = item_valid_reg && action_reg == ACTION_TICK && timer_reg;

    mslb_slots #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_en  (req_en),
        .tick_en (tick_en),
        .mask    (mask_reg),
        .count   (count_reg),
        .status  (status)
    );

    assign gathered = status.high != '0 || status.low != '0;

    always_comb
    begin
        timer_next       = timer_reg;
        write_valid_next = tick_en;
        high_next        = '0;
        low_next         = '0;
        accepted_next    = req_en && !status.overlap && status.free_found;
        // a full table still starts the timer
        if (req_en && !status.overlap)
            timer_next = 1'b1;
        if (tick_en)
        begin
            if (gathered)
            begin
                high_next = status.high;
                low_next  = status.low;
            end
            else
            begin
                high_next  = led_pin_mask_reg;
                timer_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            timer_reg        <= 1'b0;
            led_pin_mask_reg <= '0;
            done_reg         <= 1'b0;
            write_valid_reg  <= 1'b0;
            accepted_reg     <= 1'b0;
        end
        else
        begin
            item_valid_reg  <= start && !busy;
            timer_reg       <= timer_next;
            done_reg        <= item_valid_reg;
            write_valid_reg <= write_valid_next;
            accepted_reg    <= accepted_next;
            if (cfg_valid && cfg_ready)
                led_pin_mask_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            action_reg <= action;
            mask_reg   <= pin_mask;
            count_reg  <= blink_count;
        end
        high_reg <= high_next;
        low_reg  <= low_next;
    end

    assign done            = done_reg;
    assign write_valid     = write_valid_reg;
    assign drive_high_mask = high_reg;
    assign drive_low_mask  = low_reg;
    assign accepted        = accepted_reg;
    assign timer_running   = timer_reg;

endmodule

`default_nettype wire
